### sv/mbps_pkg.sv
`timescale 1ns / 1ps

package mbps_pkg;

  // Window depth in bytes; the chain has one cell per window position
  localparam int PATTERN_MAX = 32;
  localparam int WIN_IDX_W   = $clog2(PATTERN_MAX);
  localparam int WIN_BITS    = 8 * PATTERN_MAX;

  // Pattern storage is fixed by the four 64-bit pattern words
  localparam int PAT_WORDS   = 4;
  localparam int PAT_BYTES   = 32;
  localparam int PAT_BITS    = 8 * PAT_BYTES;

  // Offset counter and result field widths
  localparam int OFFSET_BITS = 32;
  localparam int OFF_W       = 32;
  localparam int TGT_W       = 34;
  localparam int LEN_W       = 6;
  localparam int LEFT_W      = 3;
  localparam int DISP_W      = 32;

  // Relative call / jump opcodes and the length of that instruction
  localparam logic [7:0]       OP_CALL_REL = 8'hE8;
  localparam logic [7:0]       OP_JMP_REL  = 8'hE9;
  localparam logic [LEN_W-1:0] BR_INSN_LEN = LEN_W'(5);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PAT0   = 3'd0,
    REG_PAT1   = 3'd1,
    REG_PAT2   = 3'd2,
    REG_PAT3   = 3'd3,
    REG_CARE   = 3'd4,
    REG_LEN    = 3'd5,
    REG_FOLLOW = 3'd6
  } cfg_reg_t;

  // Window compare summary handed from the cell row to the control
  typedef struct packed {
    logic              hit;
    logic [7:0]        first_byte;
    logic [DISP_W-1:0] disp_at_hit;
    logic [DISP_W-1:0] disp_tail;
  } scan_t;

endpackage

### sv/masked_byte_pattern_scanner_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// in_       to block   in_valid/in_stall   in_data_byte, in_last_byte
// out_      from block out_valid/out_stall out_found, out_match_offset,
//                                          out_is_branch, out_target_offset,
//                                          out_target_valid
// cfg_      to block   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per clock while in_stall is low: each request is compared against
// the whole window in the cycle it is accepted; a result it completes lands in
// the output register at the next edge; the cell row and compare set the rate.
// Reset (rst_n low, synchronous) clears the window fill, region state,
// output valid and all configuration registers.
// in_stall rises only while a result waits in the output register and the
// sink stalls; cfg_ready is always high.
module masked_byte_pattern_scanner_unit import mbps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_last_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [OFF_W-1:0]        out_match_offset,
  output logic                    out_is_branch,
  output logic signed [TGT_W-1:0] out_target_offset,
  output logic                    out_target_valid,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [63:0]             cfg_data
);

  logic [PAT_WORDS-1:0][63:0] pat_r;
  logic [PAT_BYTES-1:0]       care_r;
  logic [LEN_W-1:0]           len_r;
  logic                       follow_r;

  logic                       step;
  logic [PAT_BITS-1:0]        pat_flat, pat_rev, pat_al;
  logic [PAT_BYTES-1:0]       care_rev, care_al, use_al;
  logic [LEN_W-1:0]           al_sh;
  logic                       len_ok;

  logic [PATTERN_MAX-1:0][7:0] win_q, win_nxt;
  logic [PATTERN_MAX-1:0]      vld_q, vld_nxt, ok_v;
  logic [WIN_IDX_W-1:0]        first_idx, disp_idx;
  logic [WIN_BITS-1:0]         win_flat;
  logic [DISP_W-1:0]           disp_chunk, tail_chunk;
  scan_t                       scan;

  assign step      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r    <= '0;
      care_r   <= '0;
      len_r    <= '0;
      follow_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAT0:   pat_r[0] <= cfg_data;
        REG_PAT1:   pat_r[1] <= cfg_data;
        REG_PAT2:   pat_r[2] <= cfg_data;
        REG_PAT3:   pat_r[3] <= cfg_data;
        REG_CARE:   care_r   <= cfg_data[PAT_BYTES-1:0];
        REG_LEN:    len_r    <= cfg_data[LEN_W-1:0];
        REG_FOLLOW: follow_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Reverse the pattern so that a right shift aligns byte len-1-p to cell p
  assign pat_flat = pat_r;
  always_comb begin
    for (int k = 0; k < PAT_BYTES; k++) begin
      pat_rev[8*k +: 8] = pat_flat[8*(PAT_BYTES-1-k) +: 8];
      care_rev[k]       = care_r[PAT_BYTES-1-k];
    end
  end

  assign al_sh   = LEN_W'(PAT_BYTES) - len_r;
  assign pat_al  = pat_rev >> {al_sh, 3'b000};
  assign care_al = care_rev >> al_sh;
  assign use_al  = {PAT_BYTES{1'b1}} >> al_sh;
  assign len_ok  = (len_r != '0) && (len_r <= LEN_W'(PAT_BYTES))
                && (32'(len_r) <= 32'(PATTERN_MAX));

  // Cell row: position 0 takes the incoming byte
  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_cell
    logic [7:0] c_pat;
    logic       c_care, c_use;

    if (p == 0) begin : g_head
      assign win_nxt[p] = in_data_byte;
      assign vld_nxt[p] = 1'b1;
    end else begin : g_body
      assign win_nxt[p] = win_q[p-1];
      assign vld_nxt[p] = vld_q[p-1];
    end

    if (p < PAT_BYTES) begin : g_pat
      assign c_pat  = pat_al[8*p +: 8];
      assign c_care = care_al[p];
      assign c_use  = use_al[p];
    end else begin : g_nopat
      assign c_pat  = '0;
      assign c_care = 1'b0;
      assign c_use  = 1'b0;
    end

    mbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .clr      (in_last_byte),
      .data_in  (win_nxt[p]),
      .vld_in   (vld_nxt[p]),
      .pat_in   (c_pat),
      .care_in  (c_care),
      .use_in   (c_use),
      .data_out (win_q[p]),
      .vld_out  (vld_q[p]),
      .ok       (ok_v[p])
    );
  end

  // Pick the hit's first byte and the displacement bytes out of the window
  assign win_flat   = win_nxt;
  assign first_idx  = WIN_IDX_W'(len_r - LEN_W'(1));
  assign disp_idx   = (len_r >= BR_INSN_LEN) ? WIN_IDX_W'(len_r - BR_INSN_LEN) : '0;
  assign disp_chunk = DISP_W'(win_flat >> {disp_idx, 3'b000});
  assign tail_chunk = win_flat[DISP_W-1:0];

  always_comb begin
    scan.hit         = len_ok && vld_nxt[first_idx] && (&ok_v);
    scan.first_byte  = 8'(win_flat >> {first_idx, 3'b000});
    // Older bytes sit at higher positions: byte-reverse for little-endian
    scan.disp_at_hit = {disp_chunk[7:0], disp_chunk[15:8],
                        disp_chunk[23:16], disp_chunk[31:24]};
    scan.disp_tail   = {tail_chunk[7:0], tail_chunk[15:8],
                        tail_chunk[23:16], tail_chunk[31:24]};
  end

  mbps_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (step),
    .last              (in_last_byte),
    .scan              (scan),
    .len               (len_r),
    .follow            (follow_r),
    .out_stall         (out_stall),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_match_offset  (out_match_offset),
    .out_is_branch     (out_is_branch),
    .out_target_offset (out_target_offset),
    .out_target_valid  (out_target_valid)
  );

endmodule

### sv/mbps_cell.sv
`timescale 1ns / 1ps

// One window position: holds a byte and its valid flag, passes both on
// to the next position on every accepted request, and compares the byte
// it is about to hold with its aligned pattern byte.
module mbps_cell import mbps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       clr,
  input  logic [7:0] data_in,
  input  logic       vld_in,
  input  logic [7:0] pat_in,
  input  logic       care_in,
  input  logic       use_in,
  output logic [7:0] data_out,
  output logic       vld_out,
  output logic       ok
);

  logic [7:0] data_r;
  logic       vld_r;

  // Shift the byte along the chain
  always_ff @(posedge clk) begin
    if (step) begin
      data_r <= data_in;
    end
  end

  // Track fill; drop it at the end of a region
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (step) begin
      vld_r <= clr ? 1'b0 : vld_in;
    end
  end

  // Position outside the pattern or wildcard always passes
  assign ok       = !use_in || !care_in || (data_in == pat_in);
  assign data_out = data_r;
  assign vld_out  = vld_r;

endmodule

### sv/mbps_ctrl.sv
`timescale 1ns / 1ps

// Region control: offset counter, first-hit latch, displacement wait
// and the result output register.
module mbps_ctrl import mbps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   last,
  input  scan_t                  scan,
  input  logic [LEN_W-1:0]       len,
  input  logic                   follow,
  input  logic                   out_stall,
  output logic                   in_stall,
  output logic                   out_valid,
  output logic                   out_found,
  output logic [OFF_W-1:0]       out_match_offset,
  output logic                   out_is_branch,
  output logic signed [TGT_W-1:0] out_target_offset,
  output logic                   out_target_valid
);

  logic [OFFSET_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                   given_r, given_nxt;
  logic                   await_r, await_nxt;
  logic [OFF_W-1:0]       held_r, held_nxt;
  logic [LEFT_W-1:0]      left_r, left_nxt, left_dec, left_hit;
  logic [OFF_W-1:0]       off;
  logic                   br_byte;
  logic [OFF_W-1:0]       tgt_base;
  logic [DISP_W-1:0]      tgt_disp;
  logic [TGT_W-1:0]       tgt_sum;

  logic                   emit;
  logic                   e_found, e_branch, e_tvalid, e_resolve;
  logic [OFF_W-1:0]       e_off;

  logic                   out_valid_r;
  logic                   found_r, branch_r, tvalid_r;
  logic [OFF_W-1:0]       moff_r;
  logic [TGT_W-1:0]       tgt_r;

  // Saturating byte count and start offset of the current window
  always_comb begin
    cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + OFFSET_BITS'(1);
    off     = OFF_W'(cnt_inc - OFFSET_BITS'(len));
    br_byte = (scan.first_byte == OP_CALL_REL) || (scan.first_byte == OP_JMP_REL);
    left_dec = (left_r != '0) ? left_r - LEFT_W'(1) : left_r;
    left_hit = (len >= BR_INSN_LEN) ? '0 : LEFT_W'(BR_INSN_LEN - len);
  end

  // One adder serves both the hit and the delayed displacement
  always_comb begin
    tgt_base = await_r ? held_r : off;
    tgt_disp = await_r ? scan.disp_tail : scan.disp_at_hit;
    tgt_sum  = TGT_W'(tgt_base) + TGT_W'(BR_INSN_LEN)
             + {{(TGT_W-DISP_W){tgt_disp[DISP_W-1]}}, tgt_disp};
  end

  // Region state and result selection
  always_comb begin
    cnt_nxt   = cnt_r;
    given_nxt = given_r;
    await_nxt = await_r;
    held_nxt  = held_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    e_found   = 1'b0;
    e_off     = '0;
    e_branch  = 1'b0;
    e_resolve = 1'b0;
    e_tvalid  = 1'b0;
    if (step) begin
      cnt_nxt = cnt_inc;
      if (await_r) begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          emit      = 1'b1;
          e_found   = 1'b1;
          e_off     = held_r;
          e_branch  = 1'b1;
          e_resolve = 1'b1;
          e_tvalid  = 1'b1;
          await_nxt = 1'b0;
        end else if (last) begin
          emit     = 1'b1;
          e_found  = 1'b1;
          e_off    = held_r;
          e_branch = 1'b1;
        end
      end else if (!given_r) begin
        if (scan.hit) begin
          given_nxt = 1'b1;
          if (follow && br_byte) begin
            if (left_hit == '0) begin
              emit      = 1'b1;
              e_found   = 1'b1;
              e_off     = off;
              e_branch  = 1'b1;
              e_resolve = 1'b1;
              e_tvalid  = 1'b1;
            end else if (last) begin
              emit     = 1'b1;
              e_found  = 1'b1;
              e_off    = off;
              e_branch = 1'b1;
            end else begin
              await_nxt = 1'b1;
              held_nxt  = off;
              left_nxt  = left_hit;
            end
          end else begin
            emit     = 1'b1;
            e_found  = 1'b1;
            e_off    = off;
            e_tvalid = 1'b1;
          end
        end else if (last) begin
          emit = 1'b1;
        end
      end
      // Restart the region after its final byte
      if (last) begin
        cnt_nxt   = '0;
        given_nxt = 1'b0;
        await_nxt = 1'b0;
        held_nxt  = '0;
        left_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      given_r <= 1'b0;
      await_r <= 1'b0;
      held_r  <= '0;
      left_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      given_r <= given_nxt;
      await_r <= await_nxt;
      held_r  <= held_nxt;
      left_r  <= left_nxt;
    end
  end

  // Output register: load a result, drop valid once it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      found_r  <= e_found;
      moff_r   <= e_off;
      branch_r <= e_branch;
      tvalid_r <= e_tvalid;
      tgt_r    <= e_resolve ? tgt_sum : TGT_W'(e_off);
    end
  end

  assign in_stall          = out_valid_r && out_stall;
  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_match_offset  = moff_r;
  assign out_is_branch     = branch_r;
  assign out_target_offset = $signed(tgt_r);
  assign out_target_valid  = tvalid_r;

  a_await_given: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> given_r)
    else $error("displacement wait without a recorded hit");

  a_await_left: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (left_r != '0) && (left_r <= LEFT_W'(4)))
    else $error("displacement byte count out of range");

  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last) |=> (!await_r && !given_r && cnt_r == '0))
    else $error("region state not cleared after final byte");

  a_hit_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !last && scan.hit && !given_r) |=> given_r)
    else $error("first hit not latched");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mbps_pkg::*;

  localparam int ITEM_TARGET   = 1450;
  localparam int QUIET_TAIL    = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 3000;

  // Index past the last register; writes to it must change nothing
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                    found;
    logic [OFF_W-1:0]        match_offset;
    logic                    is_branch;
    logic signed [TGT_W-1:0] target_offset;
    logic                    target_valid;
  } hit_report_t;

  // Scan predictor plus the queue of reports it owes
  class hit_tracker;
    logic [PAT_BITS-1:0]    pattern;
    logic [31:0]            care;
    logic [LEN_W-1:0]       length;
    logic                   follow;
    logic [7:0]             window [PATTERN_MAX];
    logic [OFFSET_BITS-1:0] seen;
    logic                   reported;
    logic                   waiting_disp;
    logic [OFF_W-1:0]       held_off;
    int unsigned            disp_left;
    hit_report_t            due_reports [$];
    int                     errors;

    function new();
      pattern = '0;
      care    = '0;
      length  = '0;
      follow  = 1'b0;
      errors  = 0;
      clear_region();
    endfunction

    function void clear_region();
      int unsigned i;
      for (i = 0; i < PATTERN_MAX; i++) window[i] = 8'h00;
      seen         = '0;
      reported     = 1'b0;
      waiting_disp = 1'b0;
      held_off     = '0;
      disp_left    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_PAT0:   pattern[63:0]    = val;
        REG_PAT1:   pattern[127:64]  = val;
        REG_PAT2:   pattern[191:128] = val;
        REG_PAT3:   pattern[255:192] = val;
        REG_CARE:   care             = val[31:0];
        REG_LEN:    length           = val[LEN_W-1:0];
        REG_FOLLOW: follow           = val[0];
        default:    ;
      endcase
    endfunction

    function hit_report_t report(logic f, logic [OFF_W-1:0] off, logic br,
                                 logic [TGT_W-1:0] tgt, logic v);
      hit_report_t r;
      r.found         = f;
      r.match_offset  = off;
      r.is_branch     = br;
      r.target_offset = tgt;
      r.target_valid  = v;
      return r;
    endfunction

    // Append a report to the tail of the owed queue
    function void owe(hit_report_t r);
      due_reports = {due_reports, r};
    endfunction

    // Displacement byte k-1 sits at window position base-k, little endian
    function logic [TGT_W-1:0] branch_target(logic [OFF_W-1:0] off, int unsigned base);
      logic [31:0] disp;
      int unsigned k;
      for (k = 1; k <= 4; k++) disp[8*(k-1) +: 8] = window[(base - k) % PATTERN_MAX];
      return TGT_W'(off) + TGT_W'(BR_INSN_LEN) + {{(TGT_W-32){disp[31]}}, disp};
    endfunction

    // Advance the window by one accepted byte and queue any report it causes
    function void take_byte(logic [7:0] b, logic last);
      int unsigned len;
      int unsigned i;
      logic ok;
      logic [7:0] first;
      logic [OFF_W-1:0] off;
      for (i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = b;
      if (seen != '1) seen++;
      if (waiting_disp) begin
        if (disp_left > 0) disp_left--;
        if (disp_left == 0) begin
          owe(report(1'b1, held_off, 1'b1, branch_target(held_off, 4), 1'b1));
          waiting_disp = 1'b0;
        end else if (last) begin
          owe(report(1'b1, held_off, 1'b1, TGT_W'(held_off), 1'b0));
        end
      end else if (!reported) begin
        len = length;
        ok = len >= 1 && len <= PAT_BYTES && len <= PATTERN_MAX && seen >= len;
        for (i = 0; ok && i < len; i++) begin
          if (care[i] && window[len - 1 - i] != pattern[8*i +: 8]) ok = 1'b0;
        end
        if (ok) begin
          off      = OFF_W'(seen - len);
          first    = window[len - 1];
          reported = 1'b1;
          if (follow && (first == OP_CALL_REL || first == OP_JMP_REL)) begin
            if (len >= BR_INSN_LEN) begin
              owe(report(1'b1, off, 1'b1, branch_target(off, len - 1), 1'b1));
            end else if (last) begin
              owe(report(1'b1, off, 1'b1, TGT_W'(off), 1'b0));
            end else begin
              waiting_disp = 1'b1;
              held_off     = off;
              disp_left    = BR_INSN_LEN - len;
            end
          end else begin
            owe(report(1'b1, off, 1'b0, TGT_W'(off), 1'b1));
          end
        end else if (last) begin
          owe(report(1'b0, '0, 1'b0, '0, 1'b0));
        end
      end
      if (last) clear_region();
    endfunction

    // Compare one accepted result with the oldest report owed
    function void check_report(hit_report_t got);
      hit_report_t want;
      if (due_reports.size() == 0) begin
        $error("result with nothing due: found=%0d match_offset=%0d",
               got.found, got.match_offset);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.match_offset !== want.match_offset) begin
        $error("match_offset: expected %0d, actual %0d", want.match_offset, got.match_offset);
        errors++;
      end
      if (got.is_branch !== want.is_branch) begin
        $error("is_branch: expected %0d, actual %0d", want.is_branch, got.is_branch);
        errors++;
      end
      if (got.target_offset !== want.target_offset) begin
        $error("target_offset: expected %0d, actual %0d",
               want.target_offset, got.target_offset);
        errors++;
      end
      if (got.target_valid !== want.target_valid) begin
        $error("target_valid: expected %0d, actual %0d", want.target_valid, got.target_valid);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              in_data_byte;
  logic                    in_last_byte;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_found;
  logic [OFF_W-1:0]        out_match_offset;
  logic                    out_is_branch;
  logic signed [TGT_W-1:0] out_target_offset;
  logic                    out_target_valid;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [2:0]              cfg_index;
  logic [63:0]             cfg_data;

  hit_tracker  board;
  logic [7:0]  region_bytes [$];
  int unsigned sent_items;
  logic        quiet;
  logic        long_hold_req;

  masked_byte_pattern_scanner_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_offset  (out_match_offset),
    .out_is_branch     (out_is_branch),
    .out_target_offset (out_target_offset),
    .out_target_valid  (out_target_valid),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random byte with extra weight on branch opcodes and all-zero/all-one
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0:       return OP_CALL_REL;
      1:       return OP_JMP_REL;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Append one byte to the region being built
  function automatic void add_byte(logic [7:0] b);
    region_bytes = {region_bytes, b};
  endfunction

  // Write one register; lower valid for a cycle so writes never merge
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one byte, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    board.take_byte(b, last);
    sent_items++;
  endtask

  task automatic send_region();
    int i;
    for (i = 0; i < region_bytes.size(); i++) begin
      send_byte(region_bytes[i], i == region_bytes.size() - 1);
    end
  endtask

  // Short fixed region, byte 0 in the low bits of seq
  task automatic send_run(input logic [63:0] seq, input int n);
    int i;
    region_bytes.delete();
    for (i = 0; i < n; i++) add_byte(seq[8*i +: 8]);
    send_region();
  endtask

  // Hold the input until every owed report is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result sink: random stall bursts, one long hold on request
  initial begin : sink
    int unsigned hold_left;
    hit_report_t got;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.found         = out_found;
        got.match_offset  = out_match_offset;
        got.is_branch     = out_is_branch;
        got.target_offset = out_target_offset;
        got.target_valid  = out_target_valid;
        board.check_report(got);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end else if (hold_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 14);
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Abort when no channel moves for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[masked_byte_pattern_scanner_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [PAT_BITS-1:0] pat;
    logic [31:0]         care;
    logic                follow;
    int unsigned         len;
    int unsigned         span;
    int unsigned         kind;
    int unsigned         phase;
    int unsigned         i;
    int unsigned         j;
    board         = new();
    sent_items    = 0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_PAT0;
    cfg_data     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero length after reset: never matches
    send_run(64'hFF_00, 2);

    drain();
    write_reg(REG_PAT0, 64'hE9);
    write_reg(REG_CARE, 64'h1);
    write_reg(REG_LEN, 64'd1);
    write_reg(REG_FOLLOW, 64'd1);
    // Jump resolved from the four bytes after the hit
    send_run(64'h55_00_00_00_01_E9, 6);
    // Region ends before the displacement is complete
    send_run(64'h02_E9_11, 3);

    drain();
    write_reg(REG_PAT0, 64'h00_FF_FF_FF_FC_E8);
    write_reg(REG_CARE, 64'h1F);
    write_reg(REG_LEN, 64'd6);
    // Region shorter than the pattern
    send_run(64'hFC_E8, 2);
    // Displacement already inside the match, last byte wildcarded
    send_run(64'h00_77_FF_FF_FF_FC_E8, 7);

    drain();
    write_reg(REG_LEN, 64'd33);
    // Length past the pattern store never matches
    send_run(64'hAA, 1);

    // Random phases: new setting, then a handful of regions
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      drain();
      for (i = 0; i < 8; i++) pat[32*i +: 32] = $urandom;
      if ($urandom_range(0, 1) == 1) begin
        pat[7:0] = ($urandom_range(0, 1) == 1) ? OP_CALL_REL : OP_JMP_REL;
      end
      kind = $urandom_range(0, 9);
      if (kind < 4) care = '1;
      else if (kind == 4) care = '0;
      else care = $urandom;
      kind = $urandom_range(0, 15);
      if (kind == 0) len = 0;
      else if (kind == 1) len = $urandom_range(33, 63);
      else if (kind == 2) len = PAT_BYTES;
      else if (kind == 3) len = 1;
      else if (kind < 6) len = $urandom_range(13, 31);
      else len = $urandom_range(2, 12);
      follow = $urandom_range(0, 2) != 0;
      // Open with the extremes
      case (phase)
        0: begin
          len  = PAT_BYTES;
          care = '1;
        end
        1: len = 63;
        2: len = 1;
        3: len = 0;
        default: ;
      endcase
      for (i = 0; i < PAT_WORDS; i++) write_reg(3'(REG_PAT0 + i), pat[64*i +: 64]);
      write_reg(REG_CARE, {$urandom, care});
      write_reg(REG_LEN, {$urandom, 26'($urandom), 6'(len)});
      write_reg(REG_FOLLOW, {$urandom, 31'($urandom), follow});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
      // Short one-byte pattern: results pile up behind a long sink hold
      if (phase == 2) long_hold_req = 1'b1;

      repeat ($urandom_range(2, 6)) begin
        quiet = sent_items >= ITEM_TARGET - QUIET_TAIL;
        region_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // Noise, a copy of the pattern with random wildcards, noise
          repeat ($urandom_range(0, 6)) add_byte(noise_byte());
          span = (len >= 1 && len <= PAT_BYTES) ? len : $urandom_range(1, 8);
          for (i = 0; i < span; i++) begin
            add_byte(care[i] ? pat[8*i +: 8] : noise_byte());
          end
          // Break the copy: flip bits in one byte or drop its end
          if (kind == 6) begin
            if ($urandom_range(0, 1) == 1) begin
              j = region_bytes.size() - span + $urandom_range(0, span - 1);
              region_bytes[j] = region_bytes[j] ^ 8'($urandom_range(1, 255));
            end else begin
              void'(region_bytes.pop_back());
            end
          end
          repeat ($urandom_range(0, 6)) add_byte(noise_byte());
        end else begin
          repeat ($urandom_range(1, 20)) add_byte(noise_byte());
        end
        if (region_bytes.size() == 0) add_byte(noise_byte());
        send_region();
      end
      phase++;
    end

    drain();
    if (board.errors == 0) begin
      $display("[masked_byte_pattern_scanner_unit] OK");
    end else begin
      $display("[masked_byte_pattern_scanner_unit] ERROR");
    end
    $finish;
  end

endmodule

### masked_byte_pattern_scanner_unit.f
sv/mbps_pkg.sv
sv/mbps_cell.sv
sv/mbps_ctrl.sv
sv/masked_byte_pattern_scanner_unit.sv
dv/testbench.sv
